// ----- design/bcfs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcfs_pkg: shared definitions of the cover-fill scaler
// Sizes, field widths, sequencer states, register indexes and divider status.
// ----------------------------------------------------------------------------
package bcfs_pkg;

	localparam int STORE_BYTES = 131072;
	localparam int ROW_BYTES   = 64;
	localparam int MAX_DIM     = 1024;

	localparam int ADDR_W = $clog2(STORE_BYTES);
	localparam int DX_W   = $clog2(ROW_BYTES * 8);
	localparam int POS_W  = $clog2(ROW_BYTES);

	// Divider operand widths: numerators reach (crop + row) * size.
	localparam int NUM_W = 31;
	localparam int DEN_W = 11;

	localparam logic [7:0] FILL_BYTE = 8'hFF;
	localparam int         BIT_MSB   = 7;

	typedef enum logic [1:0] {
		REG_SOURCE_WIDTH  = 2'd0,
		REG_SOURCE_HEIGHT = 2'd1,
		REG_TARGET_WIDTH  = 2'd2,
		REG_TARGET_HEIGHT = 2'd3
	} bcfs_reg_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MUL1,
		S_MUL2,
		S_CROP_GO,
		S_CROP_WT,
		S_SY_MUL,
		S_SY_GO,
		S_SY_WT,
		S_BASE_MUL,
		S_STEP_GO,
		S_STEP_WT,
		S_Q0_MUL,
		S_Q0_GO,
		S_Q0_WT,
		S_PIX,
		S_DRAIN
	} bcfs_state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} bcfs_div_stat_t;

endpackage

// ----- design/bcfs_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcfs_ram: generic single-write, single-read memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bcfs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- design/bcfs_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcfs_div: iterative restoring divider
// One quotient bit per cycle while it runs; done follows the last bit.
// ----------------------------------------------------------------------------
module bcfs_div #(
	parameter int NUM_W = bcfs_pkg::NUM_W,
	parameter int DEN_W = bcfs_pkg::DEN_W
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [NUM_W-1:0]        num,
	input  logic [DEN_W-1:0]        den,
	output bcfs_pkg::bcfs_div_stat_t stat,
	output logic [NUM_W-1:0]        quot,
	output logic [DEN_W-1:0]        rem
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic             run_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0] n_q;
	logic [DEN_W-1:0] r_q;
	logic [DEN_W-1:0] d_q;

	logic [DEN_W:0]   rem_sh;
	logic             fits;
	logic [DEN_W-1:0] rem_next;

	always_comb begin
		rem_sh   = {r_q, n_q[NUM_W-1]};
		fits     = (rem_sh >= {1'b0, d_q});
		rem_next = fits ? DEN_W'(rem_sh - {1'b0, d_q}) : rem_sh[DEN_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= run_q && (cnt_q == CNT_W'(1));
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(NUM_W);
			end else if (run_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	// Shift the quotient bits in behind the numerator.
	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= num;
			r_q <= '0;
			d_q <= den;
		end else if (run_q) begin
			n_q <= {n_q[NUM_W-2:0], fits};
			r_q <= rem_next;
		end
	end

	assign stat.busy = run_q;
	assign stat.done = done_q;
	assign quot      = n_q;
	assign rem       = r_q;

endmodule

// ----- design/bitmap_cover_fill_scaler.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_cover_fill_scaler: cover-fill nearest-neighbor scaler, 1 bit/pixel
// Scales a packed source bitmap to cover a target box, centered and cropped.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: a transaction is taken at a clock edge with start high
//   and busy low. req_type 0 writes store_byte at store_address in the frame
//   store in that cycle; busy stays low. req_type 1 renders destination
//   row row_request; a row with a zero or oversized dimension, a row wider
//   than the row limit or a row past target_height produces nothing.
//   Result channel: each destination byte shows on row_number, byte_position,
//   pixel_bits and final_byte for exactly one cycle with strobe high; the
//   receiver cannot stall, so bytes leave as they complete.
//   Work for a row: four shared multiply steps and three divisions, one
//   more of each when columns are cropped (one quotient bit per cycle in
//   the shared divider), then one target pixel per cycle through the frame
//   store read port and a drain state. busy stays high until the drain
//   state ends, and the last byte shows in the first cycle with busy low.
//   Each byte leaves once its eighth pixel, or the row's last pixel, has
//   passed the store read stage and the output register.
//   Configuration: wr_en/wr_index/wr_data, to be written while busy is low; the block does not enforce this.
//   Reset clears the sizes to zero and returns the sequencer to idle; the
//   frame store content stays undefined until written.
// ----------------------------------------------------------------------------
module bitmap_cover_fill_scaler (
	input  logic                      clk,
	input  logic                      arst_n,
	// command channel
	input  logic                      start,
	output logic                      busy,
	input  logic                      req_type,
	input  logic [16:0]               store_address,
	input  logic [7:0]                store_byte,
	input  logic [9:0]                row_request,
	// configuration port
	input  logic                      wr_en,
	input  logic [1:0]                wr_index,
	input  logic [10:0]               wr_data,
	// result channel
	output logic                      strobe,
	output logic [9:0]                row_number,
	output logic [5:0]                byte_position,
	output logic [7:0]                pixel_bits,
	output logic                      final_byte
);

	localparam int NUM_W  = bcfs_pkg::NUM_W;
	localparam int DEN_W  = bcfs_pkg::DEN_W;
	localparam int ADDR_W = bcfs_pkg::ADDR_W;
	localparam int DX_W   = bcfs_pkg::DX_W;
	localparam int POS_W  = bcfs_pkg::POS_W;
	localparam int Q_W    = 16;
	localparam int CROP_W = 20;

	// Configuration registers
	logic [10:0] sw_q;
	logic [10:0] sh_q;
	logic [9:0]  tw_q;
	logic [10:0] th_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sw_q <= '0;
			sh_q <= '0;
			tw_q <= '0;
			th_q <= '0;
		end else if (wr_en) begin
			unique case (bcfs_pkg::bcfs_reg_t'(wr_index))
				bcfs_pkg::REG_SOURCE_WIDTH:  sw_q <= wr_data;
				bcfs_pkg::REG_SOURCE_HEIGHT: sh_q <= wr_data;
				bcfs_pkg::REG_TARGET_WIDTH:  tw_q <= wr_data[9:0];
				bcfs_pkg::REG_TARGET_HEIGHT: th_q <= wr_data;
			endcase
		end
	end

	// Derived sizes and the row request check
	logic [7:0]  src_pitch;
	logic [7:0]  dst_pitch;
	logic [10:0] sw_m1;
	logic [10:0] sh_m1;
	logic        row_ok;
	logic        accept;

	always_comb begin
		src_pitch = 8'((12'(sw_q) + 12'd7) >> 3);
		dst_pitch = 8'((11'(tw_q) + 11'd7) >> 3);
		sw_m1      = sw_q - 11'd1;
		sh_m1      = sh_q - 11'd1;
		row_ok     = (sw_q != '0) && (sh_q != '0) && (tw_q != '0) && (th_q != '0)
			&& (sw_q <= 11'(bcfs_pkg::MAX_DIM)) && (sh_q <= 11'(bcfs_pkg::MAX_DIM))
			&& (11'(tw_q) <= 11'(bcfs_pkg::MAX_DIM)) && (th_q <= 11'(bcfs_pkg::MAX_DIM))
			&& (11'(dst_pitch) <= 11'(bcfs_pkg::ROW_BYTES))
			&& (11'(row_request) < th_q);
	end

	// Sequencer
	bcfs_pkg::bcfs_state_t    state_q;
	bcfs_pkg::bcfs_state_t    state_d;
	bcfs_pkg::bcfs_div_stat_t div_stat;
	logic                     wide_q;
	logic [DX_W-1:0]          dx_q;
	logic                     last_dx;

	assign busy    = (state_q != bcfs_pkg::S_IDLE);
	assign accept  = start && !busy;
	assign last_dx = ({1'b0, dx_q} == tw_q - 10'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bcfs_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bcfs_pkg::S_IDLE:     if (accept && req_type && row_ok) state_d = bcfs_pkg::S_MUL1;
			bcfs_pkg::S_MUL1:     state_d = bcfs_pkg::S_MUL2;
			bcfs_pkg::S_MUL2:     state_d = bcfs_pkg::S_CROP_GO;
			bcfs_pkg::S_CROP_GO:  state_d = bcfs_pkg::S_CROP_WT;
			bcfs_pkg::S_CROP_WT:  if (div_stat.done) state_d = bcfs_pkg::S_SY_MUL;
			bcfs_pkg::S_SY_MUL:   state_d = bcfs_pkg::S_SY_GO;
			bcfs_pkg::S_SY_GO:    state_d = bcfs_pkg::S_SY_WT;
			bcfs_pkg::S_SY_WT:    if (div_stat.done) state_d = bcfs_pkg::S_BASE_MUL;
			bcfs_pkg::S_BASE_MUL: state_d = bcfs_pkg::S_STEP_GO;
			bcfs_pkg::S_STEP_GO:  state_d = bcfs_pkg::S_STEP_WT;
			bcfs_pkg::S_STEP_WT: begin
				if (div_stat.done) begin
					state_d = wide_q ? bcfs_pkg::S_PIX : bcfs_pkg::S_Q0_MUL;
				end
			end
			bcfs_pkg::S_Q0_MUL:   state_d = bcfs_pkg::S_Q0_GO;
			bcfs_pkg::S_Q0_GO:    state_d = bcfs_pkg::S_Q0_WT;
			bcfs_pkg::S_Q0_WT:    if (div_stat.done) state_d = bcfs_pkg::S_PIX;
			bcfs_pkg::S_PIX:      if (last_dx) state_d = bcfs_pkg::S_DRAIN;
			bcfs_pkg::S_DRAIN:    state_d = bcfs_pkg::S_IDLE;
		endcase
	end

	// Shared multiplier and divider controls, per state
	logic [CROP_W-1:0] mul_a;
	logic [10:0]       mul_b;
	logic              mul_en;
	logic              div_start;
	logic [NUM_W-1:0]  div_num;
	logic [DEN_W-1:0]  div_den;
	logic [NUM_W-1:0]  div_quot;
	logic [DEN_W-1:0]  div_rem;
	logic [NUM_W-1:0]  p1_q;
	logic [NUM_W-1:0]  prod_q;
	logic [CROP_W-1:0] crop_q;
	logic [10:0]       sy_q;
	logic [9:0]        dy_q;
	logic              wide_now;
	logic [DEN_W-1:0]  den_pix;

	assign wide_now = (p1_q >= prod_q);
	assign den_pix  = wide_q ? {1'b0, tw_q} : th_q;

	always_comb begin
		mul_en    = 1'b0;
		mul_a     = '0;
		mul_b     = '0;
		div_start = 1'b0;
		div_num   = '0;
		div_den   = '0;
		unique case (state_q)
			bcfs_pkg::S_MUL1: begin
				mul_en = 1'b1;
				mul_a  = CROP_W'(tw_q);
				mul_b  = sh_q;
			end
			bcfs_pkg::S_MUL2: begin
				mul_en = 1'b1;
				mul_a  = CROP_W'(th_q);
				mul_b  = sw_q;
			end
			bcfs_pkg::S_CROP_GO: begin
				div_start = 1'b1;
				div_num   = wide_now ? p1_q : prod_q;
				div_den   = wide_now ? sw_q : sh_q;
			end
			bcfs_pkg::S_SY_MUL: begin
				mul_en = 1'b1;
				mul_a  = wide_q ? CROP_W'(crop_q + CROP_W'(dy_q)) : CROP_W'(dy_q);
				mul_b  = wide_q ? sw_q : sh_q;
			end
			bcfs_pkg::S_SY_GO: begin
				div_start = 1'b1;
				div_num   = prod_q;
				div_den   = den_pix;
			end
			bcfs_pkg::S_BASE_MUL: begin
				mul_en = 1'b1;
				mul_a  = CROP_W'(sy_q);
				mul_b  = 11'(src_pitch);
			end
			bcfs_pkg::S_STEP_GO: begin
				div_start = 1'b1;
				div_num   = NUM_W'(wide_q ? sw_q : sh_q);
				div_den   = den_pix;
			end
			bcfs_pkg::S_Q0_MUL: begin
				mul_en = 1'b1;
				mul_a  = crop_q;
				mul_b  = sh_q;
			end
			bcfs_pkg::S_Q0_GO: begin
				div_start = 1'b1;
				div_num   = prod_q;
				div_den   = th_q;
			end
			default: begin
			end
		endcase
	end

	bcfs_div #(
		.NUM_W (NUM_W),
		.DEN_W (DEN_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.stat   (div_stat),
		.quot   (div_quot),
		.rem    (div_rem)
	);

	// Setup datapath: aspect compare, crop offset, source row, column step
	logic [ADDR_W-1:0] base_q;
	logic [Q_W-1:0]    inc_q;
	logic [DEN_W-1:0]  frac_q;
	logic [Q_W-1:0]    q_q;
	logic [DEN_W-1:0]  r_q;
	logic [DEN_W:0]    r_sum;
	logic              r_wrap;
	logic [10:0]       sx;
	logic [ADDR_W-1:0] raddr;
	logic [10:0]       crop_sub;

	assign crop_sub = wide_q ? th_q : {1'b0, tw_q};

	always_comb begin
		r_sum  = {1'b0, r_q} + {1'b0, frac_q};
		r_wrap = (r_sum >= {1'b0, den_pix});
		// clamp the source column to the last one
		sx     = (q_q > Q_W'(sw_m1)) ? sw_m1 : q_q[10:0];
		raddr  = base_q + ADDR_W'(sx[10:3]);
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			dy_q <= row_request;
		end
		if (mul_en) begin
			prod_q <= {11'b0, mul_a} * {20'b0, mul_b};
		end
		if (state_q == bcfs_pkg::S_MUL2) begin
			p1_q <= prod_q;
		end
		if (state_q == bcfs_pkg::S_CROP_GO) begin
			wide_q <= wide_now;
		end
		if (state_q == bcfs_pkg::S_CROP_WT && div_stat.done) begin
			crop_q <= CROP_W'((div_quot - NUM_W'(crop_sub)) >> 1);
		end
		if (state_q == bcfs_pkg::S_SY_WT && div_stat.done) begin
			sy_q <= (div_quot > NUM_W'(sh_m1)) ? sh_m1 : div_quot[10:0];
		end
		if (state_q == bcfs_pkg::S_STEP_GO) begin
			base_q <= prod_q[ADDR_W-1:0];
		end
		if (state_q == bcfs_pkg::S_STEP_WT && div_stat.done) begin
			inc_q  <= div_quot[Q_W-1:0];
			frac_q <= div_rem;
			q_q    <= '0;
			r_q    <= '0;
		end
		if (state_q == bcfs_pkg::S_Q0_WT && div_stat.done) begin
			q_q <= div_quot[Q_W-1:0];
			r_q <= div_rem;
		end
		// advance the source column by the whole and fractional step
		if (state_q == bcfs_pkg::S_PIX) begin
			if (r_wrap) begin
				q_q <= q_q + inc_q + Q_W'(1);
				r_q <= DEN_W'(r_sum - {1'b0, den_pix});
			end else begin
				q_q <= q_q + inc_q;
				r_q <= r_sum[DEN_W-1:0];
			end
			dx_q <= dx_q + DX_W'(1);
		end else begin
			dx_q <= '0;
		end
	end

	// Frame store: loads write while idle, pixel stepping reads
	logic [7:0] rdata;

	bcfs_ram #(
		.WIDTH (8),
		.DEPTH (bcfs_pkg::STORE_BYTES)
	) u_store (
		.clk   (clk),
		.we    (accept && !req_type),
		.waddr (store_address[ADDR_W-1:0]),
		.wdata (store_byte),
		.raddr (raddr),
		.rdata (rdata)
	);

	// Pixel stage: the store read is under way, hold the pixel coordinates
	logic            vld_s1;
	logic [2:0]      sxlo_s1;
	logic [DX_W-1:0] dx_s1;
	logic            last_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= (state_q == bcfs_pkg::S_PIX);
		end
	end

	always_ff @(posedge clk) begin
		sxlo_s1 <= sx[2:0];
		dx_s1   <= dx_q;
		last_s1 <= last_dx;
	end

	// Byte assembly: start from all ones, clear ink pixels, emit per byte
	logic [7:0] acc_q;
	logic [7:0] acc_next;
	logic       ink;
	logic       emit;

	always_comb begin
		ink      = !rdata[3'(bcfs_pkg::BIT_MSB) - sxlo_s1];
		acc_next = acc_q;
		if (ink) begin
			acc_next[3'(bcfs_pkg::BIT_MSB) - dx_s1[2:0]] = 1'b0;
		end
		emit     = vld_s1 && ((dx_s1[2:0] == 3'(bcfs_pkg::BIT_MSB)) || last_s1);
	end

	logic             strobe_q;
	logic [9:0]       row_q;
	logic [POS_W-1:0] pos_q;
	logic [7:0]       pix_q;
	logic             fin_q;

	always_ff @(posedge clk) begin
		if (state_q == bcfs_pkg::S_IDLE || emit) begin
			acc_q <= bcfs_pkg::FILL_BYTE;
		end else if (vld_s1) begin
			acc_q <= acc_next;
		end
		if (emit) begin
			row_q <= dy_q;
			pos_q <= dx_s1[DX_W-1:3];
			pix_q <= acc_next;
			fin_q <= last_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= emit;
		end
	end

	assign strobe        = strobe_q;
	assign row_number    = row_q;
	assign byte_position = pos_q;
	assign pixel_bits    = pix_q;
	assign final_byte    = fin_q;

	// Checks
	// A byte leaves only after a pixel step has passed the pixel stage and the strobe register.
	a_strobe_after_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(state_q == bcfs_pkg::S_PIX, 2))
		else $error("result byte without a pixel step");

	// The last byte of a row is never followed at once by another byte.
	a_gap_after_final: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && final_byte |=> !strobe)
		else $error("byte right after the last byte of a row");

	// The shared divider is started only when it is free.
	a_div_free: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_stat.busy)
		else $error("divider started while running");

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the cover-fill 1 bpp scaler
// Loads source bytes and requests destination rows across many size settings.
// Every accepted transaction is replayed on a local scaler model, and each
// byte on the result channel is compared field by field with the oldest
// predicted byte.
// ----------------------------------------------------------------------------
module tb;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_ROW  = 1'b1;

	// Drain past the end of the longest row.
	localparam int DRAIN_CYCLES = 700;
	localparam int LIMIT_CYCLES = 2_000_000;
	localparam int IDLE_PERCENT = 28;

	typedef struct packed {
		logic        kind;
		logic [16:0] addr;
		logic [7:0]  data;
		logic [9:0]  row;
	} cmd_t;

	typedef struct packed {
		logic [9:0] row;
		logic [5:0] pos;
		logic [7:0] bits;
		logic       last;
	} row_byte_t;

	// DUT ports: every input starts at a known value
	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        start         = 1'b0;
	logic        busy;
	logic        req_type      = OP_LOAD;
	logic [16:0] store_address = '0;
	logic [7:0]  store_byte    = '0;
	logic [9:0]  row_request   = '0;
	logic        wr_en         = 1'b0;
	logic [1:0]  wr_index      = bcfs_pkg::REG_SOURCE_WIDTH;
	logic [10:0] wr_data       = '0;
	logic        strobe;
	logic [9:0]  row_number;
	logic [5:0]  byte_position;
	logic [7:0]  pixel_bits;
	logic        final_byte;

	// Local copy of the sizes and the frame store
	int unsigned src_w = 0;
	int unsigned src_h = 0;
	int unsigned box_w = 0;
	int unsigned box_h = 0;
	bit [7:0]    frame_copy [bcfs_pkg::STORE_BYTES];
	// Addresses that some queued load will have written before any row reads them
	bit          planned [bcfs_pkg::STORE_BYTES];

	cmd_t        pending_cmds [$];
	row_byte_t   due_bytes [$];
	cmd_t        on_port;
	bit          port_loaded = 1'b0;
	bit          steady_feed = 1'b0;

	int          mismatches    = 0;
	int          loads_taken   = 0;
	int          rows_taken    = 0;
	int          rows_rendered = 0;
	int          bytes_checked = 0;
	int          settings_used = 0;
	int          cycle_count   = 0;

	bitmap_cover_fill_scaler DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.req_type      (req_type),
		.store_address (store_address),
		.store_byte    (store_byte),
		.row_request   (row_request),
		.wr_en         (wr_en),
		.wr_index      (wr_index),
		.wr_data       (wr_data),
		.strobe        (strobe),
		.row_number    (row_number),
		.byte_position (byte_position),
		.pixel_bits    (pixel_bits),
		.final_byte    (final_byte)
	);

	always #10 clk = ~clk;

	// ------------------------------------------------------------------------
	// Scaler model
	// ------------------------------------------------------------------------

	// A row produces bytes only with all sizes in 1..MAX_DIM, a row that fits
	// in ROW_BYTES and a requested row inside the box.
	function automatic bit row_has_output(input int unsigned dy);
		if (src_w == 0 || src_h == 0 || box_w == 0 || box_h == 0)
			return 1'b0;
		if (src_w > bcfs_pkg::MAX_DIM || src_h > bcfs_pkg::MAX_DIM ||
		    box_w > bcfs_pkg::MAX_DIM || box_h > bcfs_pkg::MAX_DIM)
			return 1'b0;
		if ((box_w + 7) / 8 > bcfs_pkg::ROW_BYTES)
			return 1'b0;
		return dy < box_h;
	endfunction

	// Source pixel for destination (dx, dy), as a bit index into the store:
	// byte = index >> 3, pixel within the byte = index & 7 counted from the MSB.
	function automatic longint unsigned sample_bit_index(input longint unsigned dy,
	                                                     input longint unsigned dx);
		longint unsigned sw, sh, tw, th, crop, sy, sx;
		sw = src_w;
		sh = src_h;
		tw = box_w;
		th = box_h;
		if (tw * sh >= th * sw) begin
			// source relatively taller: scale to the box width, crop rows
			crop = (sh * tw / sw - th) / 2;
			sy = (dy + crop) * sw / tw;
			sx = dx * sw / tw;
		end else begin
			// source relatively wider: scale to the box height, crop columns
			crop = (sw * th / sh - tw) / 2;
			sy = dy * sh / th;
			sx = (dx + crop) * sh / th;
		end
		if (sy > sh - 1)
			sy = sh - 1;
		if (sx > sw - 1)
			sx = sw - 1;
		// the stride is whole bytes, so the wrap keeps the pixel position
		return (sy * ((sw + 7) / 8) * 8 + sx) % (longint'(bcfs_pkg::STORE_BYTES) * 8);
	endfunction

	// Build the destination row: start from all white, clear ink pixels,
	// queue one expected byte per destination byte.
	function automatic void render_row(input logic [9:0] dy);
		logic [7:0]      row_img [bcfs_pkg::ROW_BYTES];
		longint unsigned pick;
		int              nbytes;
		row_byte_t       rb;
		if (!row_has_output(32'(dy)))
			return;
		nbytes = (box_w + 7) / 8;
		for (int k = 0; k < bcfs_pkg::ROW_BYTES; k++)
			row_img[k] = bcfs_pkg::FILL_BYTE;
		for (int unsigned dx = 0; dx < box_w; dx++) begin
			pick = sample_bit_index(dy, dx);
			if (frame_copy[pick >> 3][bcfs_pkg::BIT_MSB - int'(pick[2:0])] == 1'b0)
				row_img[dx >> 3][bcfs_pkg::BIT_MSB - int'(dx[2:0])] = 1'b0;
		end
		for (int k = 0; k < nbytes; k++) begin
			rb.row  = dy;
			rb.pos  = k[5:0];
			rb.bits = row_img[k];
			rb.last = (k == nbytes - 1);
			due_bytes.insert(due_bytes.size(), rb);
		end
		rows_rendered++;
	endfunction

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------

	// row_request is ignored on a load: randomize it anyway
	function automatic void push_load(input logic [16:0] addr, input logic [7:0] data);
		cmd_t c;
		c.kind = OP_LOAD;
		c.addr = addr;
		c.data = data;
		c.row  = 10'($urandom_range(0, 1023));
		planned[addr] = 1'b1;
		pending_cmds.insert(pending_cmds.size(), c);
	endfunction

	// store_address and store_byte are ignored on a row request
	function automatic void push_row(input logic [9:0] dy);
		cmd_t c;
		c.kind = OP_ROW;
		c.addr = 17'($urandom_range(0, bcfs_pkg::STORE_BYTES - 1));
		c.data = 8'($urandom_range(0, 255));
		c.row  = dy;
		pending_cmds.insert(pending_cmds.size(), c);
	endfunction

	// Queue a row request, preceded by loads for every source byte it reads
	// that nothing has written yet. Return the number of transactions queued.
	function automatic int queue_row(input int unsigned dy);
		longint unsigned a;
		int              added;
		added = 0;
		if (row_has_output(dy)) begin
			for (int unsigned dx = 0; dx < box_w; dx++) begin
				a = sample_bit_index(dy, dx) >> 3;
				if (!planned[a]) begin
					push_load(a[16:0], 8'($urandom_range(0, 255)));
					added++;
				end
			end
		end
		push_row(dy[9:0]);
		return added + 1;
	endfunction

	task automatic flag_mismatch(input string what);
		mismatches++;
		$display("[%0t] mismatch: %s", $time, what);
	endtask

	// Wait until every queued transaction is taken and every predicted byte
	// has arrived, then let a row that produces nothing run out.
	task automatic settle();
		while (pending_cmds.size() != 0 || port_loaded || due_bytes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	// Write all four size registers back to back; only called while idle.
	task automatic set_sizes(input logic [10:0] sw, input logic [10:0] sh,
	                         input logic [10:0] tw, input logic [10:0] th);
		@(posedge clk);
		wr_en    <= 1'b1;
		wr_index <= bcfs_pkg::REG_SOURCE_WIDTH;
		wr_data  <= sw;
		@(posedge clk);
		wr_index <= bcfs_pkg::REG_SOURCE_HEIGHT;
		wr_data  <= sh;
		@(posedge clk);
		wr_index <= bcfs_pkg::REG_TARGET_WIDTH;
		wr_data  <= tw;
		@(posedge clk);
		wr_index <= bcfs_pkg::REG_TARGET_HEIGHT;
		wr_data  <= th;
		@(posedge clk);
		wr_en <= 1'b0;
		// target_width is a 10-bit register: the top data bit is dropped
		src_w = 32'(sw);
		src_h = 32'(sh);
		box_w = 32'(tw[9:0]);
		box_h = 32'(th);
		settings_used++;
	endtask

	// One random phase: mostly well-formed rows with their source bytes
	// loaded first, plus stray loads anywhere and rows past the box.
	task automatic run_phase(input logic [10:0] sw, input logic [10:0] sh,
	                         input logic [10:0] tw, input logic [10:0] th,
	                         input int budget);
		int made;
		int roll;
		set_sizes(sw, sh, tw, th);
		made = 0;
		while (made < budget) begin
			roll = $urandom_range(0, 99);
			if (roll < 12) begin
				push_load(17'($urandom_range(0, bcfs_pkg::STORE_BYTES - 1)),
				          8'($urandom_range(0, 255)));
				made++;
			end else if (roll < 20 && box_h < 1024) begin
				// out of range: ignored by the block, so not counted
				push_row(10'($urandom_range(box_h, 1023)));
			end else begin
				made += queue_row($urandom_range(0, box_h - 1));
			end
		end
		settle();
	endtask

	// ------------------------------------------------------------------------
	// Driver: present one queued transaction at a time; hold start until the
	// block takes it, then either advance to the next one or drop start and idle.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : feed
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (port_loaded && !busy) begin
				// taken at this edge: update the model store or predict the row
				if (on_port.kind == OP_LOAD) begin
					frame_copy[on_port.addr] = on_port.data;
					loads_taken++;
				end else begin
					render_row(on_port.row);
					rows_taken++;
				end
				port_loaded = 1'b0;
			end
			// start gets exactly one assignment here when the port is free
			if (!port_loaded) begin
				if (pending_cmds.size() != 0 &&
				    (steady_feed || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
					on_port       = pending_cmds.pop_front();
					port_loaded   = 1'b1;
					start         <= 1'b1;
					req_type      <= on_port.kind;
					store_address <= on_port.addr;
					store_byte    <= on_port.data;
					row_request   <= on_port.row;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Monitor: every strobe is one result transaction, taken at this edge.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : watch
		row_byte_t oldest;
		if (arst_n && strobe) begin
			if (due_bytes.size() == 0) begin
				flag_mismatch($sformatf("unexpected byte row %0d pos %0d bits %02h",
				                        row_number, byte_position, pixel_bits));
			end else begin
				oldest = due_bytes.pop_front();
				bytes_checked++;
				if (row_number !== oldest.row)
					flag_mismatch($sformatf("row_number %0d, want %0d",
					                        row_number, oldest.row));
				if (byte_position !== oldest.pos)
					flag_mismatch($sformatf("row %0d byte_position %0d, want %0d",
					                        oldest.row, byte_position, oldest.pos));
				if (pixel_bits !== oldest.bits)
					flag_mismatch($sformatf("row %0d byte %0d pixel_bits %02h, want %02h",
					                        oldest.row, oldest.pos, pixel_bits, oldest.bits));
				if (final_byte !== oldest.last)
					flag_mismatch($sformatf("row %0d byte %0d final_byte %0b, want %0b",
					                        oldest.row, oldest.pos, final_byte, oldest.last));
			end
		end
	end

	// Watchdog: a lost byte or a hung block stalls the scenario here.
	always @(posedge clk) begin : watchdog
		cycle_count++;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("timeout after %0d cycles, %0d bytes still expected",
			         cycle_count, due_bytes.size());
			$display("FAILED: results differ");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Scenario
	// ------------------------------------------------------------------------
	initial begin : scenario
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Sizes are zero out of reset: the row must produce nothing. Hit both
		// ends of the store address range on the way.
		push_load('0, 8'h00);
		push_load(17'(bcfs_pkg::STORE_BYTES - 1), 8'hFF);
		push_row(10'd0);
		settle();

		// 1:1 copy of an 8x4 image: output equals the source bytes. Also ask
		// for the first row past the box and the highest row number.
		set_sizes(11'd8, 11'd4, 11'd8, 11'd4);
		push_load(17'd0, 8'h00);
		push_load(17'd1, 8'hFF);
		push_load(17'd2, 8'hA5);
		push_load(17'd3, 8'h5A);
		push_row(10'd0);
		push_row(10'd3);
		push_row(10'd4);
		push_row(10'd1023);
		push_row(10'd2);
		settle();

		// a size above MAX_DIM, then a row one byte wider than the limit
		set_sizes(11'd1025, 11'd4, 11'd8, 11'd4);
		push_row(10'd0);
		settle();
		set_sizes(11'd8, 11'd4, 11'd513, 11'd4);
		push_row(10'd0);
		settle();

		// each size zero in turn, then every register at its all-ones value
		for (int z = 0; z < 5; z++) begin
			case (z)
				0: set_sizes(11'd0, 11'd4, 11'd8, 11'd4);
				1: set_sizes(11'd8, 11'd0, 11'd8, 11'd4);
				2: set_sizes(11'd8, 11'd4, 11'd0, 11'd4);
				3: set_sizes(11'd8, 11'd4, 11'd8, 11'd0);
				default: set_sizes(11'h7FF, 11'h7FF, 11'h7FF, 11'h7FF);
			endcase
			push_row(10'd0);
			push_row(10'($urandom_range(0, 1023)));
			settle();
		end

		// Random phases: both crop directions, tiny and maximal boxes
		run_phase(11'd37, 11'd23, 11'd40, 11'd30, 50);
		steady_feed = 1'b1;
		run_phase(11'd20, 11'd50, 11'd64, 11'd48, 50);
		steady_feed = 1'b0;
		run_phase(11'd1, 11'd1, 11'd1, 11'd1, 15);
		run_phase(11'd100, 11'd60, 11'd512, 11'd90, 50);
		run_phase(11'd1024, 11'd1024, 11'd8, 11'd1024, 50);
		run_phase(11'd1024, 11'd1024, 11'd512, 11'd1024, 70);
		for (int g = 0; g < 3; g++)
			run_phase(11'($urandom_range(1, 80)), 11'($urandom_range(1, 80)),
			          11'($urandom_range(1, 200)), 11'($urandom_range(1, 100)), 25);

		// every phase ends in settle(), so nothing is left in flight here
		$display("Run covered %0d source loads and %0d row requests over %0d size settings",
		         loads_taken, rows_taken, settings_used);
		$display("%0d rows produced output, %0d destination bytes compared",
		         rows_rendered, bytes_checked);
		if (mismatches == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule

// ----- files.f -----
design/bcfs_pkg.sv
design/bcfs_ram.sv
design/bcfs_div.sv
design/bitmap_cover_fill_scaler.sv
verif/tb.sv
